@@ rtl/wlt_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the UID whitelist table: index width, command codes, status codes and controller states.
// No dependencies.
package wlt_pkg;

    localparam int unsigned IDX_W = 8;   // slot index / counter width (entries up to 255)

    localparam logic [3:0] MODE_ADD     = 4'd0;
    localparam logic [3:0] MODE_DEL     = 4'd1;
    localparam logic [3:0] MODE_SEARCH  = 4'd2;
    localparam logic [3:0] MODE_NEXT    = 4'd3;
    localparam logic [3:0] MODE_SETMK   = 4'd4;
    localparam logic [3:0] MODE_CLRMK   = 4'd5;
    localparam logic [3:0] MODE_ROLL    = 4'd6;
    localparam logic [3:0] MODE_CLRTAB  = 4'd7;
    localparam logic [3:0] MODE_CURRST  = 4'd8;
    localparam logic [3:0] MODE_READ    = 4'd9;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISS    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS1,
        S_PASS2,
        S_FIN
    } t_state;

endpackage

@@ rtl/wlt_cell.sv @@
`timescale 1ns / 1ps
// One slot of the whitelist ring: identifier, use bit and mark bits.
// Hands its contents to the neighbouring cell on every shift. Uses no package.
module wlt_cell #(
    parameter int MARK_TABLES = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [31:0]            i_id,
    input  logic                   i_use,
    input  logic [MARK_TABLES-1:0] i_marks,
    output logic [31:0]            o_id,
    output logic                   o_use,
    output logic [MARK_TABLES-1:0] o_marks
);
    logic [31:0]            r_id;
    logic                   r_use;
    logic [MARK_TABLES-1:0] r_marks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use   <= 1'b0;
            r_marks <= '0;
        end else if (i_shift) begin
            r_use   <= i_use;
            r_marks <= i_marks;
        end
    end

    // identifier needs no reset: only read where the use bit is set
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_id <= i_id;
        end
    end

    assign o_id    = r_id;
    assign o_use   = r_use;
    assign o_marks = r_marks;
endmodule

@@ rtl/uid_whitelist_table.sv @@
`timescale 1ns / 1ps
// Top level of the UID whitelist table: ring of wlt_cell slots plus the command controller.
// Depends on wlt_pkg and wlt_cell.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  command | in        | i_in_valid / o_in_ready   | i_mode, i_card_id, i_table_sel, i_slot
//  result  | out       | o_out_valid / i_out_ready | o_status, o_position, o_id_out,
//          |           |                           | o_entry_count
//
// Each command rotates the ring once; add and delete that change the table rotate it a
// second time to write the chosen slot.
// Reset clears all use and mark bits; identifiers are left as they are.
// A finished result waits in the output register; the next command is taken meanwhile and
// only stalls at its end if the previous result has still not been taken.
module uid_whitelist_table #(
    parameter int ENTRIES     = 128,
    parameter int MARK_TABLES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_mode,
    input  logic [31:0] i_card_id,
    input  logic [3:0]  i_table_sel,
    input  logic [6:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_position,
    output logic [31:0] o_id_out,
    output logic [7:0]  o_entry_count
);
    import wlt_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] NENT = IDX_W'(ENTRIES);
    localparam logic [IDX_W-1:0] NMT  = IDX_W'(MARK_TABLES);

    // ring wiring; cell 0 is the head seen by the controller
    logic [31:0]            w_id    [ENTRIES];
    logic                   w_use   [ENTRIES];
    logic [MARK_TABLES-1:0] w_marks [ENTRIES];
    logic [31:0]            w_fb_id;
    logic                   w_fb_use;
    logic [MARK_TABLES-1:0] w_fb_marks;
    logic                   w_shift;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_head;
    logic [3:0]       r_mode;
    logic [31:0]      r_id;
    logic [3:0]       r_sel;
    logic [6:0]       r_slot;
    logic             r_hit, r_free, r_ge, r_any, r_rd;
    logic [IDX_W-1:0] r_hit_idx, r_free_idx, r_ge_idx, r_any_idx;
    logic [31:0]      r_ge_id, r_any_id, r_rd_id;
    logic [IDX_W-1:0] r_count, r_cursor;
    logic             r_o_valid;
    logic [1:0]       r_o_status;
    logic [6:0]       r_o_pos;
    logic [31:0]      r_o_id;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic [31:0]            w_nid;
            logic                   w_nuse;
            logic [MARK_TABLES-1:0] w_nmarks;
            if (g == ENTRIES - 1) begin : g_tail
                assign w_nid    = w_fb_id;
                assign w_nuse   = w_fb_use;
                assign w_nmarks = w_fb_marks;
            end else begin : g_mid
                assign w_nid    = w_id[g+1];
                assign w_nuse   = w_use[g+1];
                assign w_nmarks = w_marks[g+1];
            end
            wlt_cell #(.MARK_TABLES(MARK_TABLES)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_id    (w_nid),
                .i_use   (w_nuse),
                .i_marks (w_nmarks),
                .o_id    (w_id[g]),
                .o_use   (w_use[g]),
                .o_marks (w_marks[g])
            );
        end
    endgenerate

    // head decode
    logic       w_match, w_mapbit, w_slot_ok, w_sel_mk, w_at_slot, w_last;
    logic [IDX_W-1:0] w_slot8;

    assign w_slot8   = IDX_W'(r_slot);
    assign w_slot_ok = w_slot8 < NENT;
    assign w_sel_mk  = (r_sel != 4'd0) && (IDX_W'(r_sel) <= NMT);
    assign w_at_slot = r_head == w_slot8;
    assign w_match   = w_use[0] && (w_id[0] == r_id);
    assign w_last    = r_head == LAST;

    always_comb begin
        w_mapbit = 1'b0;
        if (r_sel == 4'd0) begin
            w_mapbit = w_use[0];
        end
        for (int j = 0; j < MARK_TABLES; j++) begin
            if (IDX_W'(r_sel) == IDX_W'(j + 1)) begin
                w_mapbit = w_marks[0][j];
            end
        end
    end

    // head modification fed back into the tail of the ring
    always_comb begin
        w_fb_id    = w_id[0];
        w_fb_use   = w_use[0];
        w_fb_marks = w_marks[0];
        if (r_state == S_PASS1) begin
            case (r_mode)
                MODE_SETMK, MODE_CLRMK: begin
                    if (w_sel_mk && w_slot_ok && w_at_slot) begin
                        for (int j = 0; j < MARK_TABLES; j++) begin
                            if (IDX_W'(r_sel) == IDX_W'(j + 1)) begin
                                w_fb_marks[j] = (r_mode == MODE_SETMK);
                            end
                        end
                    end
                end
                MODE_ROLL: begin
                    w_fb_marks[1] = w_marks[0][0];
                    w_fb_marks[0] = 1'b0;
                end
                MODE_CLRTAB: begin
                    if (r_sel == 4'd0) begin
                        w_fb_use = 1'b0;
                    end
                    for (int j = 0; j < MARK_TABLES; j++) begin
                        if (IDX_W'(r_sel) == IDX_W'(j + 1)) begin
                            w_fb_marks[j] = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_PASS2) begin
            if (r_mode == MODE_ADD && r_head == r_free_idx) begin
                w_fb_id  = r_id;
                w_fb_use = 1'b1;
            end
            if (r_mode == MODE_DEL && r_head == r_hit_idx) begin
                w_fb_use = 1'b0;
            end
        end
    end

    // second pass needed only when add or delete changes a slot;
    // a match in the last slot still counts as already present
    logic w_need2;
    assign w_need2 = (r_mode == MODE_ADD && !r_hit && !w_match && (r_free || !w_use[0]))
                   || (r_mode == MODE_DEL && (r_hit || w_match));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PASS1;
            S_PASS1: if (w_last) n_state = w_need2 ? S_PASS2 : S_FIN;
            S_PASS2: if (w_last) n_state = S_FIN;
            S_FIN:   if (!r_o_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_shift    = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_PASS1: w_shift    = 1'b1;
            S_PASS2: w_shift    = 1'b1;
            S_FIN:   ;
            default: ;
        endcase
    end

    // result of the finished command
    logic [1:0]       w_status;
    logic [IDX_W-1:0] w_pos, w_count, w_cursor;
    logic [31:0]      w_idout;

    always_comb begin
        w_status = ST_MISS;
        w_pos    = '0;
        w_idout  = '0;
        w_count  = r_count;
        w_cursor = r_cursor;
        case (r_mode)
            MODE_ADD: begin
                if (r_hit) begin
                    w_status = ST_PRESENT;
                    w_pos    = r_hit_idx;
                end else if (r_free) begin
                    w_status = ST_DONE;
                    w_pos    = r_free_idx;
                    if (r_count < NENT) w_count = r_count + 1'b1;
                end else begin
                    w_status = ST_FULL;
                end
            end
            MODE_DEL: begin
                if (r_hit) begin
                    w_status = ST_DONE;
                    w_pos    = r_hit_idx;
                    if (r_count != '0) w_count = r_count - 1'b1;
                end
            end
            MODE_SEARCH: begin
                if (r_hit) begin
                    w_status = ST_DONE;
                    w_pos    = r_hit_idx;
                end
            end
            MODE_NEXT: begin
                if (r_ge) begin
                    w_status = ST_DONE;
                    w_pos    = r_ge_idx;
                    w_idout  = r_ge_id;
                    w_cursor = r_ge_idx + 1'b1;
                end else if (r_any) begin
                    w_status = ST_DONE;
                    w_pos    = r_any_idx;
                    w_idout  = r_any_id;
                    w_cursor = r_any_idx + 1'b1;
                end
            end
            MODE_SETMK, MODE_CLRMK: begin
                if (w_sel_mk && w_slot_ok) begin
                    w_status = ST_DONE;
                    w_pos    = w_slot8;
                end
            end
            MODE_ROLL: w_status = ST_DONE;
            MODE_CLRTAB: begin
                if (r_sel == 4'd0) begin
                    w_status = ST_DONE;
                    w_count  = '0;
                end else if (IDX_W'(r_sel) <= NMT) begin
                    w_status = ST_DONE;
                end
            end
            MODE_CURRST: begin
                w_status = ST_DONE;
                w_cursor = '0;
            end
            MODE_READ: begin
                if (r_rd) begin
                    w_status = ST_DONE;
                    w_pos    = w_slot8;
                    w_idout  = r_rd_id;
                end
            end
            default: ;
        endcase
    end

    logic w_fin_go;
    assign w_fin_go = (r_state == S_FIN) && (!r_o_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_cursor  <= '0;
            r_o_valid <= 1'b0;
            r_hit <= 1'b0; r_free <= 1'b0; r_ge <= 1'b0; r_any <= 1'b0; r_rd <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_shift) begin
                r_head <= w_last ? '0 : r_head + 1'b1;
            end
            if (o_in_ready && i_in_valid) begin
                r_hit <= 1'b0; r_free <= 1'b0; r_ge <= 1'b0; r_any <= 1'b0; r_rd <= 1'b0;
            end
            if (r_state == S_PASS1) begin
                if (w_match && !r_hit) r_hit <= 1'b1;
                if (!w_use[0] && !r_free) r_free <= 1'b1;
                if (w_mapbit && r_head >= r_cursor && !r_ge) r_ge <= 1'b1;
                if (w_mapbit && !r_any) r_any <= 1'b1;
                if (w_at_slot && w_use[0]) r_rd <= 1'b1;
            end
            // a new result replaces one taken in the same cycle
            if (w_fin_go) begin
                r_o_valid <= 1'b1;
                r_count   <= w_count;
                r_cursor  <= w_cursor;
            end else if (o_out_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode <= i_mode;
            r_id   <= i_card_id;
            r_sel  <= i_table_sel;
            r_slot <= i_slot;
        end
        if (r_state == S_PASS1) begin
            if (w_match && !r_hit) r_hit_idx <= r_head;
            if (!w_use[0] && !r_free) r_free_idx <= r_head;
            if (w_mapbit && r_head >= r_cursor && !r_ge) begin
                r_ge_idx <= r_head;
                r_ge_id  <= w_use[0] ? w_id[0] : 32'd0;
            end
            if (w_mapbit && !r_any) begin
                r_any_idx <= r_head;
                r_any_id  <= w_use[0] ? w_id[0] : 32'd0;
            end
            if (w_at_slot) r_rd_id <= w_id[0];
        end
        if (w_fin_go) begin
            r_o_status <= w_status;
            r_o_pos    <= w_pos[6:0];
            r_o_id     <= w_idout;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_position    = r_o_pos;
    assign o_id_out      = r_o_id;
    assign o_entry_count = r_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NENT) else $error("entry count above table size");
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= NENT) else $error("scan cursor out of range");
    a_head_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_FIN) |-> r_head == '0)
        else $error("ring not aligned outside a pass");
    a_full_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_position == 7'd0 && o_id_out == 32'd0))
        else $error("full result carries a slot");
endmodule
